// ===== rtl/crrp_pkg.sv =====
// Shared types and constants for the contiguous record ring pointer block.
`timescale 1ns / 1ps
`default_nettype none

package crrp_pkg;

    // Largest ring the pointers can address.
    localparam logic [10:0] RING_BYTES = 11'd1024;

    // Reset values of the configuration registers.
    localparam logic [10:0] BUFFER_SIZE_RESET = 11'd1024;
    localparam logic [10:0] MAX_RECORD_RESET  = 11'd72;

    // Configuration register indexes.
    localparam logic REG_BUFFER_SIZE = 1'b0;
    localparam logic REG_MAX_RECORD  = 1'b1;

    // Item operation codes; the unused code behaves as a query.
    typedef enum logic [1:0] {
        MODE_ADV_READ  = 2'd0,
        MODE_ADV_WRITE = 2'd1,
        MODE_QUERY     = 2'd2
    } t_mode;

endpackage

`default_nettype wire

// ===== rtl/crrp_item_if.sv =====
// Input channel carrying one pointer operation per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface crrp_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [10:0] amount;

    modport source (output valid, output mode, output amount, input ready);
    modport sink   (input valid, input mode, input amount, output ready);
endinterface

`default_nettype wire

// ===== rtl/crrp_result_if.sv =====
// Output channel carrying the pointers and free space after each operation.
`timescale 1ns / 1ps
`default_nettype none

interface crrp_result_if;
    logic        valid;
    logic        ready;
    logic [10:0] free_bytes;
    logic [10:0] read_position;
    logic [10:0] write_position;

    modport source (output valid, output free_bytes, output read_position,
                    output write_position, input ready);
    modport sink   (input valid, input free_bytes, input read_position,
                    input write_position, output ready);
endinterface

`default_nettype wire

// ===== rtl/contiguous_record_ring_pointers.sv =====
// Read and write pointer keeper for a byte ring of contiguous records.
`timescale 1ns / 1ps
`default_nettype none

// Tracks the read and write positions of a byte ring in which every record is
// stored contiguously: when fewer than one maximum record of bytes remain
// before the end of the ring, a position wraps to zero. Each transfer on the
// item channel advances the read position, advances the write position, or
// only queries; each returns one result with both positions and the usable
// free bytes. One item is accepted every clock cycle unless both stages are
// full and the result channel stalls. The pointer update and the first stage
// are registered in the accept cycle; the free-space sum is formed from the
// first stage and registered in the output register, which offers the result.
// A stalled result channel holds back new items only once both stages are
// full. Configuration writes take effect on the next cycle and must be made
// while no item is in flight.
module contiguous_record_ring_pointers (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    crrp_item_if.sink          i_item,
    crrp_result_if.source      o_result,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [10:0]   i_cfg_data
);

    // Configuration registers.
    logic [10:0] r_buf_size;
    logic [10:0] r_max_record;

    // Ring pointers.
    logic [10:0] r_rd_ptr;
    logic [10:0] n_rd_ptr;
    logic [10:0] r_wr_ptr;
    logic [10:0] n_wr_ptr;

    // Middle stage and output register.
    logic        r_s1_valid;
    logic [10:0] r_s1_rd;
    logic [10:0] r_s1_wr;
    logic        r_out_valid;
    logic [10:0] r_out_free;
    logic [10:0] r_out_rd;
    logic [10:0] r_out_wr;

    logic [10:0] size;
    logic [10:0] rec;
    logic [11:0] size_x;
    logic [11:0] rec_x;
    logic [11:0] rd_pred;
    logic [11:0] wr_pred;
    logic        rd_wrap;
    logic        wr_wrap;
    logic        advance;
    logic        accept;
    logic [11:0] tail;
    logic [11:0] free_sum;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_size   <= crrp_pkg::BUFFER_SIZE_RESET;
            r_max_record <= crrp_pkg::MAX_RECORD_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == crrp_pkg::REG_BUFFER_SIZE) begin
                r_buf_size <= i_cfg_data;
            end else begin
                r_max_record <= i_cfg_data;
            end
        end
    end

    // Effective size is clamped to 1..RING_BYTES, the record size to at least 1.
    always_comb begin
        if (r_buf_size == 11'd0) begin
            size = 11'd1;
        end else if (r_buf_size > crrp_pkg::RING_BYTES) begin
            size = crrp_pkg::RING_BYTES;
        end else begin
            size = r_buf_size;
        end
        rec    = (r_max_record == 11'd0) ? 11'd1 : r_max_record;
        size_x = {1'b0, size};
        rec_x  = {1'b0, rec};
    end

    // Pipeline flow: the output register frees up when empty or taken.
    assign advance      = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_s1_valid || advance;
    assign accept       = i_item.valid && i_item.ready;

    // Candidate positions and the wrap test for each.
    assign rd_pred = {1'b0, r_rd_ptr} + {1'b0, i_item.amount};
    assign wr_pred = {1'b0, r_wr_ptr} + {1'b0, i_item.amount};
    assign rd_wrap = (rd_pred > size_x) || ((size_x - rd_pred) < rec_x);
    assign wr_wrap = (wr_pred > size_x) || ((size_x - wr_pred) < rec_x);

    // Next pointer values for the operation on the channel.
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        case (i_item.mode)
            crrp_pkg::MODE_ADV_READ: begin
                if (r_rd_ptr < r_wr_ptr) begin
                    if (rd_pred <= {1'b0, r_wr_ptr}) begin
                        n_rd_ptr = rd_pred[10:0];
                    end
                end else if (r_rd_ptr > r_wr_ptr) begin
                    n_rd_ptr = rd_wrap ? 11'd0 : rd_pred[10:0];
                end
            end
            crrp_pkg::MODE_ADV_WRITE: begin
                if (wr_wrap) begin
                    if (r_rd_ptr != 11'd0) begin
                        n_wr_ptr = 11'd0;
                    end
                end else if ((r_wr_ptr >= r_rd_ptr) || (wr_pred < {1'b0, r_rd_ptr})) begin
                    n_wr_ptr = wr_pred[10:0];
                end
            end
            default: begin
                n_rd_ptr = r_rd_ptr;
                n_wr_ptr = r_wr_ptr;
            end
        endcase
    end

    // Pointer state and first stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr   <= 11'd0;
            r_wr_ptr   <= 11'd0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_rd_ptr <= n_rd_ptr;
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_item.ready) begin
                r_s1_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rd <= n_rd_ptr;
            r_s1_wr <= n_wr_ptr;
        end
    end

    // Usable free bytes: only regions of at least one maximum record count.
    always_comb begin
        tail     = (size_x > {1'b0, r_s1_wr}) ? (size_x - {1'b0, r_s1_wr}) : 12'd0;
        free_sum = 12'd0;
        if (r_s1_rd == r_s1_wr) begin
            free_sum = size_x;
        end else if (r_s1_rd < r_s1_wr) begin
            free_sum = ((tail >= rec_x) ? tail : 12'd0)
                     + ((r_s1_rd >= rec) ? {1'b0, r_s1_rd} : 12'd0);
        end else begin
            free_sum = ({1'b0, r_s1_rd} - {1'b0, r_s1_wr} >= rec_x)
                     ? ({1'b0, r_s1_rd} - {1'b0, r_s1_wr}) : 12'd0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_free <= free_sum[10:0];
            r_out_rd   <= r_s1_rd;
            r_out_wr   <= r_s1_wr;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.free_bytes     = r_out_free;
    assign o_result.read_position  = r_out_rd;
    assign o_result.write_position = r_out_wr;

    // Pointers never pass the largest ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_ptr <= crrp_pkg::RING_BYTES) && (r_wr_ptr <= crrp_pkg::RING_BYTES))
        else $error("ring pointer beyond ring size");

    // A query leaves both pointers untouched.
    a_query_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.mode != crrp_pkg::MODE_ADV_READ)
                && (i_item.mode != crrp_pkg::MODE_ADV_WRITE))
        |=> ($stable(r_rd_ptr) && $stable(r_wr_ptr)))
        else $error("query transfer moved a pointer");

    // With both stages full and the result stalled, no new item is taken.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_result.ready) |-> !i_item.ready)
        else $error("item accepted into a full pipeline");

    // Reported free space never exceeds the ring.
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_free <= crrp_pkg::RING_BYTES))
        else $error("free bytes beyond ring size");

endmodule

`default_nettype wire

// ===== test/crrp_checker.sv =====
// Checker that predicts and compares every result of the ring pointer block.
`timescale 1ns / 1ps

module crrp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    crrp_item_if             i_item,
    crrp_result_if           i_result,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    output int               o_failures,
    output int               o_pending,
    output int               o_checked
);

    // Positions and free space that one transfer on the result channel carries.
    typedef struct packed {
        logic [10:0] free_bytes;
        logic [10:0] read_position;
        logic [10:0] write_position;
    } t_ring_status;

    t_ring_status expected_status_q[$];

    // Shadow copy of the pointers and the configuration registers.
    int unsigned shadow_rd;
    int unsigned shadow_wr;
    int unsigned ring_size_cfg;
    int unsigned record_cfg;

    int failure_total;
    int accepted_items;
    int checked_results;

    assign o_pending = accepted_items - checked_results;
    assign o_checked = checked_results;

    // A position wraps when it runs past the ring or leaves less than one record.
    function automatic bit needs_wrap(input int unsigned pos, input int unsigned span,
                                      input int unsigned rec);
        return (pos > span) || ((span - pos) < rec);
    endfunction

    // Applies one operation to the shadow pointers and returns the new status.
    function automatic t_ring_status step_ring_pointers(input logic [1:0] op,
                                                        input logic [10:0] amt);
        int unsigned span;
        int unsigned rec;
        int unsigned target;
        int unsigned free_total;
        int unsigned tail;
        t_ring_status status;
        span = (ring_size_cfg == 0) ? 1 : ring_size_cfg;
        if (span > crrp_pkg::RING_BYTES) begin
            span = crrp_pkg::RING_BYTES;
        end
        rec = (record_cfg == 0) ? 1 : record_cfg;

        case (op)
            crrp_pkg::MODE_ADV_READ: begin
                target = shadow_rd + amt;
                if (shadow_rd < shadow_wr) begin
                    if (target <= shadow_wr) begin
                        shadow_rd = target;
                    end
                end else if (shadow_rd > shadow_wr) begin
                    shadow_rd = needs_wrap(target, span, rec) ? 0 : target;
                end
            end
            crrp_pkg::MODE_ADV_WRITE: begin
                target = shadow_wr + amt;
                if (needs_wrap(target, span, rec)) begin
                    if (shadow_rd > 0) begin
                        shadow_wr = 0;
                    end
                end else if (shadow_wr >= shadow_rd || target < shadow_rd) begin
                    shadow_wr = target;
                end
            end
            default: begin
                // Query and the spare code leave the pointers alone.
            end
        endcase
        shadow_rd = shadow_rd & 'h7FF;
        shadow_wr = shadow_wr & 'h7FF;

        // Only regions that can hold a whole record count as free.
        free_total = 0;
        if (shadow_rd == shadow_wr) begin
            free_total = span;
        end else if (shadow_rd < shadow_wr) begin
            tail = (span > shadow_wr) ? span - shadow_wr : 0;
            if (tail >= rec) begin
                free_total += tail;
            end
            if (shadow_rd >= rec) begin
                free_total += shadow_rd;
            end
        end else if ((shadow_rd - shadow_wr) >= rec) begin
            free_total = shadow_rd - shadow_wr;
        end

        status.free_bytes     = free_total[10:0];
        status.read_position  = shadow_rd[10:0];
        status.write_position = shadow_wr[10:0];
        return status;
    endfunction

    // Counts a failure and reports the first few in detail.
    function automatic void flag_result(input string what, input t_ring_status want,
                                        input t_ring_status got);
        failure_total++;
        if (failure_total <= 10) begin
            $display("[%0t] %s: free %0d/%0d read %0d/%0d write %0d/%0d (expected/actual)",
                     $realtime, what, want.free_bytes, got.free_bytes,
                     want.read_position, got.read_position,
                     want.write_position, got.write_position);
        end
    endfunction

    // Watch both channels and the register port at every rising edge.
    always @(posedge i_clk) begin : watch
        t_ring_status got;
        t_ring_status want;
        if (!i_rst_n) begin
            shadow_rd     = 0;
            shadow_wr     = 0;
            ring_size_cfg = crrp_pkg::BUFFER_SIZE_RESET;
            record_cfg    = crrp_pkg::MAX_RECORD_RESET;
            failure_total = 0;
            expected_status_q.delete();
            accepted_items  <= 0;
            checked_results <= 0;
            o_failures      <= 0;
        end else begin
            // Compare a completed result transfer with the oldest expectation.
            if (i_result.valid && i_result.ready) begin
                got.free_bytes     = i_result.free_bytes;
                got.read_position  = i_result.read_position;
                got.write_position = i_result.write_position;
                if (expected_status_q.size() == 0) begin
                    flag_result("unexpected result", '0, got);
                end else begin
                    want = expected_status_q.pop_front();
                    if (want.free_bytes !== got.free_bytes ||
                        want.read_position !== got.read_position ||
                        want.write_position !== got.write_position) begin
                        flag_result("result mismatch", want, got);
                    end
                end
                checked_results <= checked_results + 1;
            end

            // Register writes only happen while nothing is in flight.
            if (i_cfg_we) begin
                if (i_cfg_index == crrp_pkg::REG_BUFFER_SIZE) begin
                    ring_size_cfg = i_cfg_data;
                end else if (i_cfg_index == crrp_pkg::REG_MAX_RECORD) begin
                    record_cfg = i_cfg_data;
                end
            end

            // Predict the result of every accepted item transfer.
            if (i_item.valid && i_item.ready) begin
                expected_status_q.push_back(step_ring_pointers(i_item.mode, i_item.amount));
                accepted_items <= accepted_items + 1;
            end
            o_failures <= failure_total;
        end
    end

endmodule

// ===== test/testbench.sv =====
// Top of the ring pointer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    // The fourth operation code is unused by the block and acts as a query.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES = 8;
    localparam int OPS_PER_PHASE = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [10:0] i_cfg_data;
    bit          quiet;

    int failures;
    int pending;
    int checked;
    int sent_ops;
    int cycles;

    crrp_item_if   item_ch ();
    crrp_result_if result_ch ();

    contiguous_record_ring_pointers i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    crrp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .i_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Idle lengths: mostly none or short, now and then long.
    function automatic int pick_idle(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Mostly producer and consumer traffic, some queries and the spare code.
    function automatic logic [1:0] pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return crrp_pkg::MODE_ADV_WRITE;
        end
        if (roll < 85) begin
            return crrp_pkg::MODE_ADV_READ;
        end
        if (roll < 95) begin
            return crrp_pkg::MODE_QUERY;
        end
        return MODE_SPARE;
    endfunction

    // Amounts are mostly record sized, so the pointers walk the whole ring.
    function automatic logic [10:0] pick_amount(input int unsigned span,
                                                input int unsigned rec);
        int roll;
        int unsigned ring_top;
        roll = $urandom_range(0, 99);
        ring_top = (span > crrp_pkg::RING_BYTES) ? crrp_pkg::RING_BYTES : span;
        if (roll < 65) begin
            return 11'($urandom_range(0, rec));
        end
        if (roll < 85) begin
            return 11'($urandom_range(0, ring_top));
        end
        if (roll < 95) begin
            return 11'($urandom_range(0, 2047));
        end
        return (roll < 97) ? 11'd0 : 11'd2047;
    endfunction

    // Result side: random stalls, none while calm is set.
    initial begin : result_sink
        int stall_left;
        int idle;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                idle = pick_idle(quiet);
                if (idle == 0) begin
                    result_ch.ready <= 1'b1;
                end else begin
                    result_ch.ready <= 1'b0;
                    stall_left = idle - 1;
                end
            end
        end
    end

    // Offer one item after a random gap and hold it until the transfer.
    task automatic send_op(input logic [1:0] op, input logic [10:0] amt);
        int idle;
        idle = pick_idle(quiet);
        if (idle > 0) begin
            item_ch.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.mode   <= op;
        item_ch.amount <= amt;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        sent_ops++;
    endtask

    // Stop offering items until every outstanding result has come back.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back cycles.
    task automatic write_regs(input logic [10:0] span, input logic [10:0] rec);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= crrp_pkg::REG_BUFFER_SIZE;
        i_cfg_data  <= span;
        @(posedge i_clk);
        i_cfg_index <= crrp_pkg::REG_MAX_RECORD;
        i_cfg_data  <= rec;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Main stimulus.
    initial begin : stimulus
        int unsigned span_list [PHASES];
        int unsigned rec_list [PHASES];
        int unsigned span;
        int unsigned rec;
        int drain_wait;
        span_list = '{1024, 1, 1024, 0, 2047, 16, 300, 0};
        rec_list  = '{72, 1, 1024, 0, 2047, 3, 40, 0};
        sent_ops = 0;
        cycles   <= 0;
        quiet    <= 1'b0;
        i_rst_n  <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= crrp_pkg::REG_BUFFER_SIZE;
        i_cfg_data  <= 11'd0;
        item_ch.valid  <= 1'b0;
        item_ch.mode   <= crrp_pkg::MODE_QUERY;
        item_ch.amount <= 11'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk at the reset settings: empty ring, wraps with and
        // without the read pointer at zero, refused moves, field extremes.
        send_op(crrp_pkg::MODE_QUERY, 11'd0);
        send_op(MODE_SPARE, 11'd2047);
        send_op(crrp_pkg::MODE_ADV_READ, 11'd5);
        send_op(crrp_pkg::MODE_ADV_WRITE, 11'd0);
        send_op(crrp_pkg::MODE_ADV_WRITE, 11'd1000);
        send_op(crrp_pkg::MODE_ADV_WRITE, 11'd2047);
        send_op(crrp_pkg::MODE_ADV_WRITE, 11'd952);
        send_op(crrp_pkg::MODE_ADV_READ, 11'd100);
        send_op(crrp_pkg::MODE_ADV_READ, 11'd900);
        send_op(crrp_pkg::MODE_ADV_WRITE, 11'd71);
        send_op(crrp_pkg::MODE_ADV_WRITE, 11'd99);
        send_op(crrp_pkg::MODE_ADV_WRITE, 11'd0);
        send_op(crrp_pkg::MODE_ADV_READ, 11'd1024);
        send_op(crrp_pkg::MODE_ADV_READ, 11'd99);
        send_op(crrp_pkg::MODE_ADV_WRITE, 11'd1024);
        send_op(crrp_pkg::MODE_ADV_READ, 11'd925);
        send_op(crrp_pkg::MODE_ADV_WRITE, 11'd1024);
        send_op(crrp_pkg::MODE_ADV_WRITE, 11'd512);
        send_op(crrp_pkg::MODE_ADV_READ, 11'd256);
        send_op(crrp_pkg::MODE_ADV_WRITE, 11'd440);
        send_op(crrp_pkg::MODE_QUERY, 11'd1365);
        send_op(crrp_pkg::MODE_ADV_READ, 11'd2047);
        send_op(crrp_pkg::MODE_ADV_READ, 11'd682);

        // Random phases, each under its own register setting. The pointers
        // are kept across phases, so a shrinking ring leaves them past its end.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            span = span_list[ph];
            rec  = rec_list[ph];
            if (ph == PHASES - 1) begin
                span = $urandom_range(1, 1024);
                rec  = $urandom_range(1, span);
            end
            write_regs(span[10:0], rec[10:0]);
            quiet <= (ph == 2 || ph == 5);
            for (int k = 0; k < OPS_PER_PHASE; k++) begin
                if (ph == 3 && k == OPS_PER_PHASE / 2) begin
                    wait_idle();
                end
                send_op(pick_op(), pick_amount(span, rec));
            end
        end

        // Let the last results drain, then give the verdict.
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        drain_wait = 0;
        while (pending != 0 && drain_wait < 4000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (8) @(posedge i_clk);
        if (pending != 0) begin
            $display("%0d expected results never arrived.", pending);
        end
        $display("Run covered %0d operations under %0d register settings.",
                 sent_ops, PHASES + 1);
        $display("Results compared: %0d, mismatches: %0d.", checked, failures);
        if (failures == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
